### rtl/core/slcp_pkg.sv
// Shared types, constants and decode functions for the SLCAN command parser.
`timescale 1ns / 1ps

package slcp_pkg;

  localparam int CharW    = 8;
  localparam int IdW      = 32;
  localparam int DlcW     = 4;
  localparam int PayW     = 64;
  localparam int RateW    = 10;
  localparam int PosW     = 5;
  localparam int KindW    = 4;
  localparam int NibW     = 4;
  localparam int IdNibs   = IdW / NibW;
  localparam int DataNibs = PayW / NibW;
  localparam int DataBytes = PayW / 8;

  localparam logic [PosW-1:0]  PosMax   = '1;
  localparam logic [PosW-1:0]  IdLenStd = 5'd3;
  localparam logic [PosW-1:0]  IdLenExt = 5'd8;
  localparam logic [DlcW-1:0]  DlcMax   = 4'd8;
  localparam logic [CharW-1:0] CharCr   = 8'd13;

  localparam logic [CharW-1:0] ChS   = "S";
  localparam logic [CharW-1:0] ChO   = "O";
  localparam logic [CharW-1:0] ChL   = "L";
  localparam logic [CharW-1:0] ChLl  = "l";
  localparam logic [CharW-1:0] ChC   = "C";
  localparam logic [CharW-1:0] ChZ   = "Z";
  localparam logic [CharW-1:0] ChF   = "F";
  localparam logic [CharW-1:0] ChV   = "V";
  localparam logic [CharW-1:0] ChVl  = "v";
  localparam logic [CharW-1:0] ChN   = "N";
  localparam logic [CharW-1:0] ChT   = "T";
  localparam logic [CharW-1:0] ChTl  = "t";
  localparam logic [CharW-1:0] ChR   = "R";
  localparam logic [CharW-1:0] ChRl  = "r";
  localparam logic [CharW-1:0] ChOne = "1";

  typedef enum logic [KindW-1:0] {
    KIND_BITRATE  = 4'd0,
    KIND_OPEN     = 4'd1,
    KIND_LISTEN   = 4'd2,
    KIND_LOOPBACK = 4'd3,
    KIND_CLOSE    = 4'd4,
    KIND_TRANSMIT = 4'd5,
    KIND_BUSY     = 4'd6,
    KIND_TS_ON    = 4'd7,
    KIND_TS_OFF   = 4'd8,
    KIND_FLAGS    = 4'd9,
    KIND_VERSION  = 4'd10,
    KIND_MINOR    = 4'd11,
    KIND_SERIAL   = 4'd12,
    KIND_UNKNOWN  = 4'd13
  } cmd_kind_t;

  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [CharW-1:0] letter;
    logic [CharW-1:0] arg;
    logic [IdW-1:0]   id;
    logic [DlcW-1:0]  len;
    logic [PayW-1:0]  data;
  } coll_state_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [RateW-1:0] bitrate;
    logic             ext_id;
    logic             rtr;
    logic [IdW-1:0]   can_id;
    logic [DlcW-1:0]  dlc;
    logic [PayW-1:0]  payload;
  } result_t;

  function automatic logic [NibW-1:0] hex_value(input logic [CharW-1:0] c);
    logic [CharW-1:0] t;
    t = 8'd0;
    if (c >= "0" && c <= "9") begin
      t = c - 8'h30;
    end else if (c >= "A" && c <= "F") begin
      t = c - 8'h37;
    end else if (c >= "a" && c <= "f") begin
      t = c - 8'h57;
    end
    return t[NibW-1:0];
  endfunction

  function automatic logic is_transmit(input logic [CharW-1:0] c);
    return (c == ChTl) || (c == ChT) || (c == ChRl) || (c == ChR);
  endfunction

  function automatic logic is_extended(input logic [CharW-1:0] c);
    return (c == ChT) || (c == ChR);
  endfunction

  function automatic logic [RateW-1:0] bitrate_of(input logic [CharW-1:0] c);
    logic [RateW-1:0] r;
    case (c)
      "0":     r = 10'd10;
      "1":     r = 10'd20;
      "2":     r = 10'd50;
      "3":     r = 10'd100;
      "4":     r = 10'd125;
      "5":     r = 10'd250;
      "6":     r = 10'd500;
      "7":     r = 10'd800;
      "8":     r = 10'd1000;
      default: r = 10'd100;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/slcp_in_if.sv
// Character input channel: valid/ready with character and controller ready.
`timescale 1ns / 1ps

interface slcp_in_if;
  import slcp_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_in;
  logic             can_ready;

  modport source (output valid, output char_in, output can_ready, input ready);
  modport sink (input valid, input char_in, input can_ready, output ready);
endinterface

### rtl/core/slcp_out_if.sv
// Decoded command channel: valid/ready with the result fields.
`timescale 1ns / 1ps

interface slcp_out_if;
  import slcp_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] cmd_kind;
  logic [RateW-1:0] bitrate_kbps;
  logic             ext_id;
  logic             rtr;
  logic [IdW-1:0]   can_id;
  logic [DlcW-1:0]  dlc;
  logic [PayW-1:0]  payload;

  modport source (output valid, output cmd_kind, output bitrate_kbps, output ext_id,
                  output rtr, output can_id, output dlc, output payload, input ready);
  modport sink (input valid, input cmd_kind, input bitrate_kbps, input ext_id,
                input rtr, input can_id, input dlc, input payload, output ready);
endinterface

### rtl/core/slcan_ascii_command_parser_top.sv
// SLCAN ASCII command parser top level: input register, collector, result register.
// Throughput: one character per cycle, except that a carriage return waits while a result is pending and not taken.
// A carriage return passes through the input register; its decoded result then loads the result register once free.
// The result register lets the next character in while a result waits to be taken.
// Reset (rst, synchronous, active high) empties both registers and clears the command.
`timescale 1ns / 1ps

module slcan_ascii_command_parser_top (
  input logic       clk,
  input logic       rst,
  slcp_in_if.sink   cmd,
  slcp_out_if.source result
);
  import slcp_pkg::*;

  logic             s1_valid;
  logic [CharW-1:0] s1_char;
  logic             s1_can_ready;
  logic             s1_cr;
  logic             s1_adv;
  logic             out_free;
  logic             out_valid;
  result_t          out_res;
  result_t          dec_res;
  coll_state_t      coll;

  assign s1_cr     = (s1_char == CharCr);
  assign out_free  = !out_valid || result.ready;
  assign s1_adv    = s1_valid && (!s1_cr || out_free);
  assign cmd.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      s1_char      <= cmd.char_in;
      s1_can_ready <= cmd.can_ready;
    end
  end

  slcp_collector u_collector (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_adv),
    .char_in (s1_char),
    .state   (coll)
  );

  slcp_decoder u_decoder (
    .state     (coll),
    .can_ready (s1_can_ready),
    .res       (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_cr) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_cr) begin
      out_res <= dec_res;
    end
  end

  assign result.valid        = out_valid;
  assign result.cmd_kind     = out_res.kind;
  assign result.bitrate_kbps = out_res.bitrate;
  assign result.ext_id       = out_res.ext_id;
  assign result.rtr          = out_res.rtr;
  assign result.can_id       = out_res.can_id;
  assign result.dlc          = out_res.dlc;
  assign result.payload      = out_res.payload;

  // command ends: collector back at the start
  a_cr_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_cr) |=> (coll.pos == '0))
    else $error("collector not cleared after carriage return");

  // a held character is never lost or altered
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_char)))
    else $error("input register dropped a character");

  // a pending result is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |-> !(s1_adv && s1_cr))
    else $error("result overwritten while stalled");

  // frame fields are zero except on a transmit
  a_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.kind != KIND_TRANSMIT)) |->
      ((out_res.can_id == '0) && (out_res.payload == '0) && (out_res.dlc == '0)))
    else $error("frame fields set on a non-transmit result");

  a_dlc_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.dlc <= DlcMax))
    else $error("length beyond clamp");
endmodule

### rtl/core/slcp_collector.sv
// Command collector: letter, argument, hex identifier, length and data nibbles.
`timescale 1ns / 1ps

module slcp_collector (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic [slcp_pkg::CharW-1:0] char_in,
  output slcp_pkg::coll_state_t     state
);
  import slcp_pkg::*;

  coll_state_t      st;
  coll_state_t      st_next;
  logic [NibW-1:0]  hex;
  logic [PosW-1:0]  idlen;
  logic [PosW-1:0]  id_nib;
  logic [PosW-1:0]  dpos;
  logic [NibW-1:0]  data_nib;

  assign hex      = hex_value(char_in);
  assign idlen    = is_extended(st.letter) ? IdLenExt : IdLenStd;
  assign id_nib   = idlen - st.pos;
  assign dpos     = st.pos - idlen - 5'd2;
  assign data_nib = dpos[NibW-1:0] ^ 4'd1;

  always_comb begin
    st_next = st;
    if (char_in == CharCr) begin
      st_next = '0;
    end else begin
      if (st.pos == '0) begin
        st_next.letter = char_in;
      end else if (is_transmit(st.letter)) begin
        if (st.pos <= idlen) begin
          for (int n = 0; n < IdNibs; n++) begin
            if (id_nib == PosW'(n)) begin
              st_next.id[n*NibW +: NibW] = st.id[n*NibW +: NibW] | hex;
            end
          end
        end else if (st.pos == idlen + 5'd1) begin
          st_next.len = hex;
        end else if (dpos < PosW'(DataNibs)) begin
          for (int n = 0; n < DataNibs; n++) begin
            if (data_nib == NibW'(n)) begin
              st_next.data[n*NibW +: NibW] = st.data[n*NibW +: NibW] | hex;
            end
          end
        end
      end else if (st.pos == 5'd1) begin
        st_next.arg = char_in;
      end
      if (st.pos != PosMax) begin
        st_next.pos = st.pos + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  assign state = st;
endmodule

### rtl/core/slcp_decoder.sv
// Command decoder: turns the collected command into a result at carriage return.
`timescale 1ns / 1ps

module slcp_decoder (
  input  slcp_pkg::coll_state_t state,
  input  logic                  can_ready,
  output slcp_pkg::result_t     res
);
  import slcp_pkg::*;

  logic [CharW-1:0] letter;
  logic [DlcW-1:0]  dlc;
  logic             rtr;

  assign letter = (state.pos == '0) ? '0 : state.letter;
  assign dlc    = (state.len > DlcMax) ? DlcMax : state.len;
  assign rtr    = (letter == ChRl) || (letter == ChR);

  always_comb begin
    res      = '0;
    res.kind = KIND_UNKNOWN;
    case (letter)
      ChS:  begin
        res.kind    = KIND_BITRATE;
        res.bitrate = bitrate_of(state.arg);
      end
      ChO:  res.kind = KIND_OPEN;
      ChL:  res.kind = KIND_LISTEN;
      ChLl: res.kind = KIND_LOOPBACK;
      ChC:  res.kind = KIND_CLOSE;
      ChZ:  res.kind = (state.arg == ChOne) ? KIND_TS_ON : KIND_TS_OFF;
      ChF:  res.kind = KIND_FLAGS;
      ChV:  res.kind = KIND_VERSION;
      ChVl: res.kind = KIND_MINOR;
      ChN:  res.kind = KIND_SERIAL;
      ChTl, ChT, ChRl, ChR: begin
        if (!can_ready) begin
          res.kind = KIND_BUSY;
        end else begin
          res.kind   = KIND_TRANSMIT;
          res.ext_id = is_extended(letter);
          res.rtr    = rtr;
          res.can_id = state.id;
          res.dlc    = dlc;
          for (int b = 0; b < DataBytes; b++) begin
            if (!rtr && (DlcW'(b) < dlc)) begin
              res.payload[b*8 +: 8] = state.data[b*8 +: 8];
            end
          end
        end
      end
      default: res.kind = KIND_UNKNOWN;
    endcase
  end
endmodule
